// File: hw/rtl/bitmap_page_run_allocator_top_defines.svh
// Assertion helpers used by the allocator controller (bpra_ctrl).
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BPRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bpra_pkg.sv
package bpra_pkg;

   localparam int MAP_WORDS = 2048;
   localparam int WORD_W    = 32;
   localparam int WORD_AW   = $clog2(MAP_WORDS);
   localparam int BIT_AW    = $clog2(WORD_W);
   localparam int PAGE_W    = WORD_AW + BIT_AW;
   localparam int RUN_W     = PAGE_W + 1;
   localparam int POS_W     = BIT_AW + 1;

   localparam logic [PAGE_W-1:0] FIRST_CHANGEABLE = PAGE_W'(2);
   localparam logic [PAGE_W-1:0] LAST_CHANGEABLE  = PAGE_W'(MAP_WORDS * WORD_W - 2);
   localparam logic [RUN_W-1:0]  MAX_COUNT        = RUN_W'(MAP_WORDS * WORD_W - 2);
   localparam logic [WORD_AW-1:0] LAST_WORD       = WORD_AW'(MAP_WORDS - 1);

   // reset contents: pages 0 and 1 and the top page reserved
   localparam logic [WORD_W-1:0] WORD_ALL_FREE   = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] WORD_FIRST_INIT = {{(WORD_W-2){1'b1}}, 2'b00};
   localparam logic [WORD_W-1:0] WORD_LAST_INIT  = {1'b0, {(WORD_W-1){1'b1}}};

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_START = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [PAGE_W-1:0] start_page;
      logic [PAGE_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] first_page;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic mark;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic load_free;
      logic alloc_bad;
      logic free_bad;
      logic free_none;
      logic found;
      logic exhausted;
      logic mark_done;
   } stat_type;

   // number of ones below the lowest zero
   function automatic logic [POS_W-1:0] trailing_ones(input logic [WORD_W-1:0] w);
      logic [POS_W-1:0] n;
      n = POS_W'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) n = POS_W'(i);
      end
      return n;
   endfunction

   // number of ones above the highest zero
   function automatic logic [POS_W-1:0] leading_ones(input logic [WORD_W-1:0] w);
      logic [POS_W-1:0] n;
      n = POS_W'(WORD_W);
      for (int i = 0; i < WORD_W; i++) begin
         if (!w[i]) n = POS_W'(WORD_W - 1 - i);
      end
      return n;
   endfunction

endpackage

// File: hw/rtl/bpra_ram.sv
module bpra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bpra_datapath.sv
module bpra_datapath (
   input  logic              clock,
   input  logic              reset,
   input  bpra_pkg::cmd_type cmd,
   output bpra_pkg::stat_type stat,
   input  bpra_pkg::req_type req_data,
   output bpra_pkg::rsp_type rsp_data
);

   localparam int WORD_W  = bpra_pkg::WORD_W;
   localparam int WORD_AW = bpra_pkg::WORD_AW;
   localparam int BIT_AW  = bpra_pkg::BIT_AW;
   localparam int PAGE_W  = bpra_pkg::PAGE_W;
   localparam int RUN_W   = bpra_pkg::RUN_W;
   localparam int POS_W   = bpra_pkg::POS_W;

   logic [WORD_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [WORD_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [WORD_AW-1:0] proc_addr_ff, proc_addr_in;
   logic               pend_ff, pend_in;
   logic               mode_ff, mode_in;
   logic [PAGE_W-1:0]  count_ff, count_in;
   logic [PAGE_W-1:0]  lo_ff, lo_in;
   logic [PAGE_W-1:0]  hi_ff, hi_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [PAGE_W-1:0]  run_start_ff, run_start_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [PAGE_W-1:0]  res_first_ff, res_first_in;
   bpra_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [WORD_AW-1:0] ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [WORD_W-1:0]  word;

   bpra_ram #(
      .WIDTH (WORD_W),
      .DEPTH (bpra_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (word)
   );

   // request decode
   logic [RUN_W-1:0]  free_end;
   logic [PAGE_W-1:0] free_hi;
   logic              alloc_bad, free_bad;

   always_comb begin
      alloc_bad = (req_data.count == '0) || ({1'b0, req_data.count} > bpra_pkg::MAX_COUNT);
      free_bad  = (req_data.start_page < bpra_pkg::FIRST_CHANGEABLE) ||
                  (req_data.start_page > bpra_pkg::LAST_CHANGEABLE);
      free_end  = {1'b0, req_data.start_page} + {1'b0, req_data.count} - RUN_W'(1);
      free_hi   = (free_end > {1'b0, bpra_pkg::LAST_CHANGEABLE}) ?
                  bpra_pkg::LAST_CHANGEABLE : free_end[PAGE_W-1:0];
   end

   // run search over one map word, joined to the run carried from earlier words
   logic [PAGE_W-1:0] base;
   logic [POS_W-1:0]  t_ones, l_ones;
   logic [RUN_W:0]    cross_sum;
   logic              cross_hit, count_small, inner_hit, hit;
   logic [WORD_W-1:0] len_mask, win_hit;
   logic [BIT_AW-1:0] inner_pos;
   logic [PAGE_W-1:0] run_begin, run_end;
   logic [RUN_W-1:0]  run_end_w;

   always_comb begin
      base        = {proc_addr_ff, {BIT_AW{1'b0}}};
      t_ones      = bpra_pkg::trailing_ones(word);
      l_ones      = bpra_pkg::leading_ones(word);
      cross_sum   = {1'b0, run_ff} + (RUN_W+1)'(t_ones);
      cross_hit   = (run_ff != '0) && (cross_sum >= (RUN_W+1)'(count_ff));
      count_small = count_ff <= PAGE_W'(WORD_W);
      len_mask    = (count_ff[PAGE_W-1:BIT_AW] != '0) ? {WORD_W{1'b1}} :
                    (({{(WORD_W-1){1'b0}}, 1'b1} << count_ff[BIT_AW-1:0]) - 1'b1);
      for (int j = 0; j < WORD_W; j++) begin
         win_hit[j] = count_small && (&((word >> j) | ~len_mask));
      end
      inner_pos = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (win_hit[j]) inner_pos = BIT_AW'(j);
      end
      inner_hit = |win_hit;
      hit       = cross_hit || inner_hit;
      run_begin = cross_hit ? run_start_ff : (base | PAGE_W'(inner_pos));
      run_end_w = {1'b0, run_begin} + {1'b0, count_ff} - RUN_W'(1);
      run_end   = run_end_w[PAGE_W-1:0];
   end

   // word update for marking
   logic [WORD_W-1:0] lo_mask, hi_mask, sel_mask, mark_data;

   always_comb begin
      lo_mask   = (proc_addr_ff == lo_ff[PAGE_W-1:BIT_AW]) ?
                  ({WORD_W{1'b1}} << lo_ff[BIT_AW-1:0]) : {WORD_W{1'b1}};
      hi_mask   = (proc_addr_ff == hi_ff[PAGE_W-1:BIT_AW]) ?
                  ({WORD_W{1'b1}} >> (BIT_AW'(WORD_W - 1) - hi_ff[BIT_AW-1:0])) :
                  {WORD_W{1'b1}};
      sel_mask  = lo_mask & hi_mask;
      mark_data = (mode_ff == bpra_pkg::MODE_FREE) ? (word | sel_mask) : (word & ~sel_mask);
   end

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      rd_addr_in    = rd_addr_ff;
      proc_addr_in  = proc_addr_ff;
      pend_in       = pend_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      run_in        = run_ff;
      run_start_in  = run_start_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = proc_addr_ff;
      ram_wr_data   = mark_data;
      ram_rd_en     = 1'b0;

      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         if (clr_addr_ff == '0) begin
            ram_wr_data = bpra_pkg::WORD_FIRST_INIT;
         end else if (clr_addr_ff == bpra_pkg::LAST_WORD) begin
            ram_wr_data = bpra_pkg::WORD_LAST_INIT;
         end else begin
            ram_wr_data = bpra_pkg::WORD_ALL_FREE;
         end
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      if (cmd.load) begin
         mode_in      = req_data.mode;
         count_in     = req_data.count;
         lo_in        = req_data.start_page;
         hi_in        = free_hi;
         run_in       = '0;
         run_start_in = '0;
         pend_in      = 1'b0;
         res_first_in = '0;
         if (req_data.mode == bpra_pkg::MODE_FREE) begin
            rd_addr_in    = req_data.start_page[PAGE_W-1:BIT_AW];
            res_status_in = free_bad ? bpra_pkg::STATUS_BAD_START : bpra_pkg::STATUS_DONE;
         end else begin
            rd_addr_in    = '0;
            res_status_in = alloc_bad ? bpra_pkg::STATUS_NO_SPACE : bpra_pkg::STATUS_DONE;
         end
      end

      if (cmd.scan) begin
         ram_rd_en    = 1'b1;
         rd_addr_in   = rd_addr_ff + 1'b1;
         proc_addr_in = rd_addr_ff;
         pend_in      = 1'b1;
         if (pend_ff) begin
            if (hit) begin
               // latch the run and restart the read pointer at its first word
               lo_in        = run_begin;
               hi_in        = run_end;
               res_first_in = run_begin;
               rd_addr_in   = run_begin[PAGE_W-1:BIT_AW];
               pend_in      = 1'b0;
            end else if (proc_addr_ff == bpra_pkg::LAST_WORD) begin
               res_status_in = bpra_pkg::STATUS_NO_SPACE;
               pend_in       = 1'b0;
            end else if (&word) begin
               run_in       = run_ff + RUN_W'(WORD_W);
               run_start_in = (run_ff == '0) ? base : run_start_ff;
            end else begin
               run_in       = RUN_W'(l_ones);
               run_start_in = base + PAGE_W'(WORD_W) - PAGE_W'(l_ones);
            end
         end
      end

      if (cmd.mark) begin
         ram_rd_en    = 1'b1;
         rd_addr_in   = rd_addr_ff + 1'b1;
         proc_addr_in = rd_addr_ff;
         pend_in      = 1'b1;
         if (pend_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = proc_addr_ff;
            ram_wr_data = mark_data;
            if (proc_addr_ff == hi_ff[PAGE_W-1:BIT_AW]) pend_in = 1'b0;
         end
      end

      if (cmd.emit) begin
         rsp_data_in.status     = res_status_ff;
         rsp_data_in.first_page = res_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
      end
      rd_addr_ff    <= rd_addr_in;
      proc_addr_ff  <= proc_addr_in;
      mode_ff       <= mode_in;
      count_ff      <= count_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      run_ff        <= run_in;
      run_start_ff  <= run_start_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      stat.clear_last = clr_addr_ff == bpra_pkg::LAST_WORD;
      stat.load_free  = req_data.mode == bpra_pkg::MODE_FREE;
      stat.alloc_bad  = alloc_bad;
      stat.free_bad   = free_bad;
      stat.free_none  = req_data.count == '0;
      stat.found      = pend_ff && hit;
      stat.exhausted  = pend_ff && !hit && (proc_addr_ff == bpra_pkg::LAST_WORD);
      stat.mark_done  = pend_ff && (proc_addr_ff == hi_ff[PAGE_W-1:BIT_AW]);
   end

   assign rsp_data = rsp_data_ff;

endmodule

// File: hw/rtl/bpra_ctrl.sv
`include "bitmap_page_run_allocator_top_defines.svh"

module bpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bpra_pkg::cmd_type  cmd,
   input  bpra_pkg::stat_type stat
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.load_free) begin
                  state_in = (stat.free_bad || stat.free_none) ? S_DONE : S_MARK;
               end else begin
                  state_in = stat.alloc_bad ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.found) begin
               state_in = S_MARK;
            end else if (stat.exhausted) begin
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (stat.mark_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BPRA_ASSERT_NEXT(a_emit_shows, clock, reset, (state_ff == S_DONE) && slot_free, rsp_valid_ff, "finished result not presented")
   `BPRA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "accepted request left controller idle")
   `BPRA_ASSERT_NEXT(a_mark_ends, clock, reset, (state_ff == S_MARK) && stat.mark_done, state_ff == S_DONE, "mark pass did not finish")

endmodule

// File: hw/rtl/bitmap_page_run_allocator_top.sv
// Allocate: load the request, scan map words until a run is found, mark the run's words, then
// hand off the result; a full miss scans all 2048 map words before reporting no space.
// Free: load the request, mark the touched words, then hand off; a rejected or empty request goes straight to hand-off.
// Throughput: one request at a time, bound by the single read and write port of the map RAM.
// Reset: a clearing pass writes the 2048 map words, one per cycle, before the first request is
// taken; pages 0, 1 and the top page come out reserved, every other page free.
module bitmap_page_run_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpra_pkg::rsp_type rsp_data
);

   // command and status between the sequencer and the map datapath
   bpra_pkg::cmd_type  cmd;
   bpra_pkg::stat_type stat;

   // sequencer: clear pass, then accept, scan, mark and hand off one request at a time
   bpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: map RAM, word-at-a-time run search, masked read-modify-write marking,
   // and the result register that lets the next request in while a result waits
   bpra_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
